/* hdl/deq_pkg.sv */
// Shared types and operation codes for the double-ended queue.
package deq_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4
    } deq_op_t;

    localparam int unsigned VALUE_W = 32;

    // Access strobes from the pointer control to the ring storage.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } deq_mem_ctl_t;

endpackage

/* hdl/deq_if.sv */
// Handshake channels for command words and response words.
interface deq_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic signed [31:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface deq_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] popped_value;
    logic               ok;

    modport source (output valid, output popped_value, output ok, input ready);
    modport sink   (input valid, input popped_value, input ok, output ready);
endinterface

/* hdl/deq_mem.sv */
// Ring storage: one write port and one read port with registered read data.
module deq_mem
    import deq_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
)
(
    input  logic                      clk,
    input  deq_mem_ctl_t              ctl,
    input  logic [AW-1:0]             waddr,
    input  logic signed [VALUE_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic signed [VALUE_W-1:0] rdata
);

    logic signed [VALUE_W-1:0] entries_reg [DEPTH];
    logic signed [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            entries_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_reg <= entries_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/deq_ctrl.sv */
// Head, tail and count control, command decode and the response register.
module deq_ctrl
    import deq_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4,
    parameter int unsigned CW    = 5
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    deq_cmd_if.sink                   cmd,
    deq_rsp_if.source                 rsp,
    output deq_mem_ctl_t              mem_ctl,
    output logic [AW-1:0]             mem_waddr,
    output logic signed [VALUE_W-1:0] mem_wdata,
    output logic [AW-1:0]             mem_raddr,
    input  logic signed [VALUE_W-1:0] mem_rdata
);

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] idx);
        return (idx == '0) ? LAST_IDX : idx - AW'(1);
    endfunction

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg;
    logic          ok_reg, ok_next;
    logic          pop_reg, pop_next;
    logic          accept;
    logic          full;
    logic          empty;
    deq_op_t       op_dec;

    assign cmd.ready = !out_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign full      = (count_reg == FULL_CNT);
    assign empty     = (count_reg == '0);
    assign op_dec    = deq_op_t'(cmd.op);
    assign mem_wdata = cmd.value;

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        ok_next        = 1'b0;
        pop_next       = 1'b0;
        mem_ctl.wr_en  = 1'b0;
        mem_ctl.rd_en  = 1'b0;
        mem_waddr      = tail_reg;
        mem_raddr      = head_reg;
        case (op_dec)
            OP_PUSH_FRONT:
            begin
                mem_waddr = ring_prev(head_reg);
                if (!full)
                begin
                    head_next     = ring_prev(head_reg);
                    count_next    = count_reg + CW'(1);
                    ok_next       = 1'b1;
                    mem_ctl.wr_en = accept;
                end
            end
            OP_PUSH_BACK:
            begin
                mem_waddr = tail_reg;
                if (!full)
                begin
                    tail_next     = ring_next(tail_reg);
                    count_next    = count_reg + CW'(1);
                    ok_next       = 1'b1;
                    mem_ctl.wr_en = accept;
                end
            end
            OP_POP_FRONT:
            begin
                mem_raddr = head_reg;
                if (!empty)
                begin
                    head_next     = ring_next(head_reg);
                    count_next    = count_reg - CW'(1);
                    ok_next       = 1'b1;
                    pop_next      = 1'b1;
                    mem_ctl.rd_en = accept;
                end
            end
            OP_POP_BACK:
            begin
                mem_raddr = ring_prev(tail_reg);
                if (!empty)
                begin
                    tail_next     = ring_prev(tail_reg);
                    count_next    = count_reg - CW'(1);
                    ok_next       = 1'b1;
                    pop_next      = 1'b1;
                    mem_ctl.rd_en = accept;
                end
            end
            OP_CLEAR:
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
                ok_next    = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg  <= ok_next;
            pop_reg <= pop_next;
        end
    end

    // The read data register only loads on an accepted pop, so it holds while stalled.
    assign rsp.valid        = out_valid_reg;
    assign rsp.ok           = ok_reg;
    assign rsp.popped_value = pop_reg ? mem_rdata : '0;

    // The tail must always sit count entries past the head, modulo the depth.
    logic [CW:0] chk_sum;
    logic [CW:0] chk_wrap;
    assign chk_sum  = (CW+1)'(head_reg) + (CW+1)'(count_reg);
    assign chk_wrap = (chk_sum >= (CW+1)'(DEPTH)) ? chk_sum - (CW+1)'(DEPTH) : chk_sum;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("occupancy count exceeds the depth");

    a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        chk_wrap[AW-1:0] == tail_reg)
        else $error("head, tail and count disagree");

    a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_ctl.wr_en && mem_ctl.rd_en))
        else $error("storage read and written by one word");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |-> !accept)
        else $error("command taken while response is stalled");

    a_access_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctl.wr_en || mem_ctl.rd_en) |-> accept)
        else $error("storage access without an accepted command");

endmodule

/* hdl/double_ended_queue_top.sv */
// Top level of the double-ended queue: ring storage plus pointer control.
// A double-ended queue of DEPTH signed 32-bit words held in a ring memory with
// head and tail pointers and an occupancy count. Every command word yields
// exactly one response word, in the cycle after it is accepted, together with
// the registered read of the ring memory, which a pop needs for its data.
// One command is accepted per cycle: the response register is one deep, and a
// new command is taken in any cycle where that register is empty or its word
// is being taken. A push on a full queue or a pop on an empty one answers with
// ok low and leaves the queue unchanged; clear answers with ok high.
module double_ended_queue_top
    import deq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    deq_cmd_if.sink   cmd,
    deq_rsp_if.source rsp
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    deq_mem_ctl_t              mem_ctl;
    logic [AW-1:0]             mem_waddr;
    logic [AW-1:0]             mem_raddr;
    logic signed [VALUE_W-1:0] mem_wdata;
    logic signed [VALUE_W-1:0] mem_rdata;

    deq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp       (rsp),
        .mem_ctl   (mem_ctl),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    deq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
